>>> rtl/core/kbet_pkg.sv
// ============================================================================
// kbet_pkg: shared definitions for the key and button edge tracker
// Sizes, state and mode codes, record layout and the control structs that
// pass between the tracker's units.
// ============================================================================
`default_nettype none

package kbet_pkg;

   localparam int unsigned KEY_COUNT    = 512;
   localparam int unsigned BUTTON_COUNT = 8;

   localparam int unsigned KEY_IDX_W = $clog2(KEY_COUNT);
   localparam int unsigned KEY_CNT_W = $clog2(KEY_COUNT + 1);
   localparam int unsigned BTN_IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

   localparam int unsigned REQ_W = 48;
   localparam int unsigned RSP_W = 88;

   typedef logic [KEY_IDX_W-1:0] key_idx_type;
   typedef logic [KEY_CNT_W-1:0] key_cnt_type;
   typedef logic [BTN_IDX_W-1:0] btn_idx_type;

   localparam logic [1:0] ST_UP       = 2'd0;
   localparam logic [1:0] ST_PRESSED  = 2'd1;
   localparam logic [1:0] ST_DOWN     = 2'd2;
   localparam logic [1:0] ST_RELEASED = 2'd3;

   typedef enum logic [3:0] {
      MODE_KEY_DOWN  = 4'd0,
      MODE_KEY_UP    = 4'd1,
      MODE_WHEEL     = 4'd2,
      MODE_MOTION    = 4'd3,
      MODE_BTN_UP    = 4'd4,
      MODE_BTN_DOWN  = 4'd5,
      MODE_TICK      = 4'd6,
      MODE_KEY_QUERY = 4'd7,
      MODE_BTN_QUERY = 4'd8
   } mode_type;

   typedef struct packed {
      logic       changed;
      logic [1:0] st;
   } rec_type;

   typedef struct packed {
      logic       event_en;
      logic       set_press;
      logic       tick;
      logic [8:0] code;
   } btn_cmd_type;

   typedef struct packed {
      logic [1:0] state;
      logic       found;
      logic [2:0] held;
   } btn_stat_type;

   typedef struct packed {
      logic               wheel_en;
      logic               move_en;
      logic               tick;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
   } mot_cmd_type;

   typedef struct packed {
      logic signed [15:0] scroll_x;
      logic signed [15:0] scroll_y;
      logic               seen;
      logic signed [16:0] dx;
      logic signed [16:0] dy;
   } mot_stat_type;

   function automatic rec_type settle(rec_type r);
      rec_type s;
      s.changed = 1'b0;
      s.st      = r.st;
      if (!r.changed) begin
         if (r.st == ST_PRESSED) begin
            s.st = ST_DOWN;
         end else if (r.st == ST_RELEASED) begin
            s.st = ST_UP;
         end
      end
      return s;
   endfunction

   function automatic logic is_held(rec_type r);
      return (r.st == ST_PRESSED) || (r.st == ST_DOWN);
   endfunction

   function automatic logic code_is_key(logic [8:0] code);
      return 32'(code) < KEY_COUNT;
   endfunction

   function automatic logic code_is_button(logic [8:0] code);
      return 32'(code) < BUTTON_COUNT;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/kbet_key_ram.sv
// ============================================================================
// kbet_key_ram: key record memory
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module kbet_key_ram (
   input  wire                  clock,
   input  wire                  wr_en,
   input  kbet_pkg::key_idx_type wr_addr,
   input  kbet_pkg::rec_type    wr_data,
   input  wire                  rd_en,
   input  kbet_pkg::key_idx_type rd_addr,
   output kbet_pkg::rec_type    rd_data
);

   kbet_pkg::rec_type mem [kbet_pkg::KEY_COUNT];
   kbet_pkg::rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/kbet_button_file.sv
// ============================================================================
// kbet_button_file: mouse button records
// Holds the button records in flip-flops, applies button events, settles them
// on a frame tick and finds the lowest held button.
// ============================================================================
`default_nettype none

module kbet_button_file (
   input  wire                    clock,
   input  wire                    reset,
   input  kbet_pkg::btn_cmd_type  cmd,
   output kbet_pkg::btn_stat_type stat
);

   kbet_pkg::rec_type button_ff [kbet_pkg::BUTTON_COUNT];
   kbet_pkg::rec_type button_in [kbet_pkg::BUTTON_COUNT];
   kbet_pkg::rec_type settled   [kbet_pkg::BUTTON_COUNT];
   kbet_pkg::btn_idx_type idx;
   logic btn_ok;

   assign idx    = kbet_pkg::btn_idx_type'(cmd.code);
   assign btn_ok = kbet_pkg::code_is_button(cmd.code);

   always_comb begin
      for (int i = 0; i < int'(kbet_pkg::BUTTON_COUNT); i++) begin
         settled[i]   = kbet_pkg::settle(button_ff[i]);
         button_in[i] = button_ff[i];
      end
      if (cmd.tick) begin
         for (int i = 0; i < int'(kbet_pkg::BUTTON_COUNT); i++) begin
            button_in[i] = settled[i];
         end
      end else if (cmd.event_en && btn_ok) begin
         button_in[idx].changed = 1'b1;
         button_in[idx].st = cmd.set_press ? kbet_pkg::ST_PRESSED : kbet_pkg::ST_RELEASED;
      end
   end

   always_comb begin
      stat.state = btn_ok ? button_ff[idx].st : kbet_pkg::ST_UP;
      stat.found = 1'b0;
      stat.held  = 3'd0;
      for (int i = int'(kbet_pkg::BUTTON_COUNT) - 1; i >= 0; i--) begin
         if (kbet_pkg::is_held(settled[i])) begin
            stat.found = 1'b1;
            stat.held  = 3'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < int'(kbet_pkg::BUTTON_COUNT); i++) begin
         if (reset) begin
            button_ff[i] <= '0;
         end else begin
            button_ff[i] <= button_in[i];
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/kbet_motion_unit.sv
// ============================================================================
// kbet_motion_unit: wheel and pointer motion accumulator
// Sums wheel steps with saturation and keeps the last motion delta of the
// frame; a frame tick clears the sums and the delta.
// ============================================================================
`default_nettype none

module kbet_motion_unit (
   input  wire                    clock,
   input  wire                    reset,
   input  kbet_pkg::mot_cmd_type  cmd,
   output kbet_pkg::mot_stat_type stat
);

   logic signed [15:0] sum_x_ff, sum_x_in;
   logic signed [15:0] sum_y_ff, sum_y_in;
   logic signed [15:0] abs_x_ff, abs_x_in;
   logic signed [15:0] abs_y_ff, abs_y_in;
   logic signed [16:0] dx_ff, dx_in;
   logic signed [16:0] dy_ff, dy_in;

   function automatic logic signed [15:0] sat_add(logic signed [15:0] a,
                                                  logic signed [15:0] b);
      logic signed [16:0] s;
      s = {a[15], a} + {b[15], b};
      if (s[16] != s[15]) begin
         return s[16] ? 16'sh8000 : 16'sh7FFF;
      end
      return s[15:0];
   endfunction

   always_comb begin
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      abs_x_in = abs_x_ff;
      abs_y_in = abs_y_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      if (cmd.tick) begin
         sum_x_in = '0;
         sum_y_in = '0;
         dx_in    = '0;
         dy_in    = '0;
      end else if (cmd.wheel_en) begin
         sum_x_in = sat_add(sum_x_ff, cmd.pos_x);
         sum_y_in = sat_add(sum_y_ff, cmd.pos_y);
      end else if (cmd.move_en) begin
         dx_in    = {cmd.pos_x[15], cmd.pos_x} - {abs_x_ff[15], abs_x_ff};
         dy_in    = {cmd.pos_y[15], cmd.pos_y} - {abs_y_ff[15], abs_y_ff};
         abs_x_in = cmd.pos_x;
         abs_y_in = cmd.pos_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         abs_x_ff <= '0;
         abs_y_ff <= '0;
         dx_ff    <= '0;
         dy_ff    <= '0;
      end else begin
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         abs_x_ff <= abs_x_in;
         abs_y_ff <= abs_y_in;
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
      end
   end

   assign stat.scroll_x = sum_x_ff;
   assign stat.scroll_y = sum_y_ff;
   assign stat.seen     = (sum_x_ff != '0) || (sum_y_ff != '0);
   assign stat.dx       = dx_ff;
   assign stat.dy       = dy_ff;

endmodule

`default_nettype wire

>>> rtl/core/key_button_edge_tracker_top.sv
// ============================================================================
// key_button_edge_tracker_top: key and mouse button edge tracker
// Keeps an up, pressed, down or released record per key and button, frame
// wheel sums and the last motion delta, and answers each beat with one result.
// ============================================================================
`default_nettype none

// Every request beat gives exactly one response beat. For key, button, wheel,
// motion and query beats the key record is read from the key memory in the
// accept cycle, and a key event that changes it writes it back once the
// output register is free. A frame tick walks the whole key memory through
// its one read and one write port, one entry per cycle. After reset the block
// clears every entry of the key memory and takes no request until then. A
// finished response waits in an output register, and the block accepts the
// next request while it waits.
module key_button_edge_tracker_top (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   // Fields from bit 0: code[8:0], pos_x[24:9], pos_y[40:25], zero fill.
   input  wire  [kbet_pkg::REQ_W-1:0]   req_tdata,
   // Fields from bit 0: mode[3:0].
   input  wire  [3:0]                   req_tuser,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   // Fields from bit 0: item_state[1:0], held_key[10:2], held_key_found[11],
   // held_button[14:12], held_button_found[15], scroll_x[31:16],
   // scroll_y[47:32], scroll_seen[48], move_dx[65:49], move_dy[82:66], zero fill.
   output logic [kbet_pkg::RSP_W-1:0]   rsp_tdata
);

   typedef enum logic [4:0] {
      S_CLEAR   = 5'b00001,
      S_IDLE    = 5'b00010,
      S_EXEC    = 5'b00100,
      S_SWEEP   = 5'b01000,
      S_TICKOUT = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   kbet_pkg::key_cnt_type      sweep_ff, sweep_in;
   logic                       wb_valid_ff, wb_valid_in;
   kbet_pkg::key_idx_type      wb_addr_ff, wb_addr_in;
   logic                       found_ff, found_in;
   kbet_pkg::key_idx_type      held_idx_ff, held_idx_in;
   kbet_pkg::mode_type         mode_ff, mode_in;
   logic [8:0]                 code_ff, code_in;
   logic signed [15:0]         px_ff, px_in;
   logic signed [15:0]         py_ff, py_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [kbet_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic                       key_wr_en, key_rd_en;
   kbet_pkg::key_idx_type      key_wr_addr, key_rd_addr;
   kbet_pkg::rec_type          key_wr_data, key_rd_data, key_settled;
   kbet_pkg::btn_cmd_type      btn_cmd;
   kbet_pkg::btn_stat_type     btn_stat;
   kbet_pkg::mot_cmd_type      mot_cmd;
   kbet_pkg::mot_stat_type     mot_stat;
   logic                       out_free, key_ok, rd_issue;
   logic [1:0]                 item_st;

   kbet_key_ram u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_wr_data),
      .rd_en   (key_rd_en),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   kbet_button_file u_button_file (
      .clock (clock),
      .reset (reset),
      .cmd   (btn_cmd),
      .stat  (btn_stat)
   );

   kbet_motion_unit u_motion_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (mot_cmd),
      .stat  (mot_stat)
   );

   assign req_tready  = (state_ff == S_IDLE);
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign key_ok      = kbet_pkg::code_is_key(code_ff);
   assign key_settled = kbet_pkg::settle(key_rd_data);
   assign rd_issue    = (sweep_ff != kbet_pkg::key_cnt_type'(kbet_pkg::KEY_COUNT));

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      wb_valid_in  = wb_valid_ff;
      wb_addr_in   = wb_addr_ff;
      found_in     = found_ff;
      held_idx_in  = held_idx_ff;
      mode_in      = mode_ff;
      code_in      = code_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      item_st      = kbet_pkg::ST_UP;

      key_wr_en    = 1'b0;
      key_wr_addr  = kbet_pkg::key_idx_type'(code_ff);
      key_wr_data  = '0;
      key_rd_en    = 1'b0;
      key_rd_addr  = kbet_pkg::key_idx_type'(req_tdata[8:0]);

      btn_cmd           = '0;
      btn_cmd.code      = code_ff;
      mot_cmd           = '0;
      mot_cmd.pos_x     = px_ff;
      mot_cmd.pos_y     = py_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            key_wr_en   = 1'b1;
            key_wr_addr = sweep_ff[kbet_pkg::KEY_IDX_W-1:0];
            sweep_in    = sweep_ff + 1'b1;
            if (sweep_ff == kbet_pkg::key_cnt_type'(kbet_pkg::KEY_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in   = kbet_pkg::mode_type'(req_tuser);
               code_in   = req_tdata[8:0];
               px_in     = req_tdata[24:9];
               py_in     = req_tdata[40:25];
               key_rd_en = 1'b1;
               if (kbet_pkg::mode_type'(req_tuser) == kbet_pkg::MODE_TICK) begin
                  state_in    = S_SWEEP;
                  sweep_in    = '0;
                  wb_valid_in = 1'b0;
                  found_in    = 1'b0;
                  held_idx_in = '0;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            if (out_free) begin
               case (mode_ff)
                  kbet_pkg::MODE_KEY_DOWN: begin
                     if (key_ok) begin
                        if (kbet_pkg::is_held(key_rd_data)) begin
                           item_st = key_rd_data.st;
                        end else begin
                           key_wr_en   = 1'b1;
                           key_wr_data = '{changed: 1'b1, st: kbet_pkg::ST_PRESSED};
                           item_st     = kbet_pkg::ST_PRESSED;
                        end
                     end
                  end
                  kbet_pkg::MODE_KEY_UP: begin
                     if (key_ok) begin
                        key_wr_en   = 1'b1;
                        key_wr_data = '{changed: 1'b1, st: kbet_pkg::ST_RELEASED};
                        item_st     = kbet_pkg::ST_RELEASED;
                     end
                  end
                  kbet_pkg::MODE_WHEEL: begin
                     mot_cmd.wheel_en = 1'b1;
                  end
                  kbet_pkg::MODE_MOTION: begin
                     mot_cmd.move_en = 1'b1;
                  end
                  kbet_pkg::MODE_BTN_UP: begin
                     btn_cmd.event_en = 1'b1;
                     if (kbet_pkg::code_is_button(code_ff)) begin
                        item_st = kbet_pkg::ST_RELEASED;
                     end
                  end
                  kbet_pkg::MODE_BTN_DOWN: begin
                     btn_cmd.event_en  = 1'b1;
                     btn_cmd.set_press = 1'b1;
                     if (kbet_pkg::code_is_button(code_ff)) begin
                        item_st = kbet_pkg::ST_PRESSED;
                     end
                  end
                  kbet_pkg::MODE_KEY_QUERY: begin
                     if (key_ok) begin
                        item_st = key_rd_data.st;
                     end
                  end
                  kbet_pkg::MODE_BTN_QUERY: begin
                     item_st = btn_stat.state;
                  end
                  default: begin
                     item_st = kbet_pkg::ST_UP;
                  end
               endcase
               rsp_valid_in = 1'b1;
               rsp_data_in  = {86'd0, item_st};
               state_in     = S_IDLE;
            end
         end
         S_SWEEP: begin
            key_rd_en   = rd_issue;
            key_rd_addr = sweep_ff[kbet_pkg::KEY_IDX_W-1:0];
            wb_valid_in = rd_issue;
            wb_addr_in  = sweep_ff[kbet_pkg::KEY_IDX_W-1:0];
            if (rd_issue) begin
               sweep_in = sweep_ff + 1'b1;
            end
            if (wb_valid_ff) begin
               key_wr_en   = 1'b1;
               key_wr_addr = wb_addr_ff;
               key_wr_data = key_settled;
               if (kbet_pkg::is_held(key_settled) && !found_ff) begin
                  found_in    = 1'b1;
                  held_idx_in = wb_addr_ff;
               end
            end
            if (!rd_issue && !wb_valid_ff) begin
               state_in = S_TICKOUT;
            end
         end
         S_TICKOUT: begin
            if (out_free) begin
               btn_cmd.tick = 1'b1;
               mot_cmd.tick = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, mot_stat.dy, mot_stat.dx, mot_stat.seen,
                               mot_stat.scroll_y, mot_stat.scroll_x,
                               btn_stat.found, btn_stat.held,
                               found_ff, 9'(held_idx_ff), kbet_pkg::ST_UP};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         wb_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         wb_valid_ff  <= wb_valid_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wb_addr_ff  <= wb_addr_in;
      held_idx_ff <= held_idx_in;
      mode_ff     <= mode_in;
      code_ff     <= code_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_sweep_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP && key_wr_en && key_rd_en) |-> (key_wr_addr != key_rd_addr))
      else $error("key sweep reads and writes the same entry");

   a_accept_moves_on: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_EXEC || state_ff == S_SWEEP))
      else $error("accepted beat did not start processing");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC || state_ff == S_TICKOUT))
      else $error("response raised outside a finishing state");
`endif

endmodule

`default_nettype wire

>>> dv/key_button_edge_tracker_checker.sv
// ============================================================================
// key_button_edge_tracker_checker: response checker for the edge tracker
// Watches the request and response streams of the tracker. It keeps its own
// copy of the key and button records, wheel sums and motion deltas, predicts
// the response of every accepted request beat and compares every response
// beat, field by field, with the oldest prediction still waiting.
// ============================================================================
module key_button_edge_tracker_checker (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   input  wire                         req_tready,
   input  wire [kbet_pkg::REQ_W-1:0]   req_tdata,
   input  wire [3:0]                   req_tuser,
   input  wire                         rsp_tvalid,
   input  wire                         rsp_tready,
   input  wire [kbet_pkg::RSP_W-1:0]   rsp_tdata,
   output int                          mismatch_count,
   output int                          responses_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [16:0] move_dy;
      logic signed [16:0] move_dx;
      logic               scroll_seen;
      logic signed [15:0] scroll_y;
      logic signed [15:0] scroll_x;
      logic               held_button_found;
      logic [2:0]         held_button;
      logic               held_key_found;
      logic [8:0]         held_key;
      logic [1:0]         item_state;
   } tracker_result_type;

   logic [1:0]         key_state [kbet_pkg::KEY_COUNT];
   logic               key_touched [kbet_pkg::KEY_COUNT];
   logic [1:0]         btn_state [kbet_pkg::BUTTON_COUNT];
   logic               btn_touched [kbet_pkg::BUTTON_COUNT];
   logic signed [15:0] wheel_x, wheel_y;
   logic signed [15:0] last_x, last_y;
   logic signed [16:0] delta_x, delta_y;

   tracker_result_type owed_results [$];

   initial begin
      mismatch_count = 0;
      responses_owed = 0;
   end

   function automatic logic signed [15:0] add_saturated(logic signed [15:0] acc,
                                                        logic signed [15:0] step);
      logic signed [16:0] sum;
      sum = acc;
      sum = sum + step;
      if (sum > 32767) begin
         return 16'sh7fff;
      end else if (sum < -32768) begin
         return 16'sh8000;
      end
      return sum[15:0];
   endfunction

   function automatic tracker_result_type tracker_response(logic [3:0] mode,
                                                           logic [8:0] code,
                                                           logic signed [15:0] px,
                                                           logic signed [15:0] py);
      tracker_result_type r;
      int i;
      r = '0;
      case (mode)
         kbet_pkg::MODE_KEY_DOWN: begin
            if (code < kbet_pkg::KEY_COUNT) begin
               if (key_state[code] != kbet_pkg::ST_PRESSED &&
                   key_state[code] != kbet_pkg::ST_DOWN) begin
                  key_state[code]   = kbet_pkg::ST_PRESSED;
                  key_touched[code] = 1'b1;
               end
               r.item_state = key_state[code];
            end
         end
         kbet_pkg::MODE_KEY_UP: begin
            if (code < kbet_pkg::KEY_COUNT) begin
               key_state[code]   = kbet_pkg::ST_RELEASED;
               key_touched[code] = 1'b1;
               r.item_state      = kbet_pkg::ST_RELEASED;
            end
         end
         kbet_pkg::MODE_WHEEL: begin
            wheel_x = add_saturated(wheel_x, px);
            wheel_y = add_saturated(wheel_y, py);
         end
         kbet_pkg::MODE_MOTION: begin
            delta_x = px;
            delta_x = delta_x - last_x;
            delta_y = py;
            delta_y = delta_y - last_y;
            last_x  = px;
            last_y  = py;
         end
         kbet_pkg::MODE_BTN_UP, kbet_pkg::MODE_BTN_DOWN: begin
            if (code < kbet_pkg::BUTTON_COUNT) begin
               btn_state[code]   = (mode == kbet_pkg::MODE_BTN_DOWN) ?
                                   kbet_pkg::ST_PRESSED : kbet_pkg::ST_RELEASED;
               btn_touched[code] = 1'b1;
               r.item_state      = btn_state[code];
            end
         end
         kbet_pkg::MODE_TICK: begin
            for (i = 0; i < kbet_pkg::KEY_COUNT; i++) begin
               if (!key_touched[i]) begin
                  if (key_state[i] == kbet_pkg::ST_PRESSED) begin
                     key_state[i] = kbet_pkg::ST_DOWN;
                  end else if (key_state[i] == kbet_pkg::ST_RELEASED) begin
                     key_state[i] = kbet_pkg::ST_UP;
                  end
               end
               key_touched[i] = 1'b0;
               if (!r.held_key_found &&
                   (key_state[i] == kbet_pkg::ST_PRESSED ||
                    key_state[i] == kbet_pkg::ST_DOWN)) begin
                  r.held_key       = i[8:0];
                  r.held_key_found = 1'b1;
               end
            end
            for (i = 0; i < kbet_pkg::BUTTON_COUNT; i++) begin
               if (!btn_touched[i]) begin
                  if (btn_state[i] == kbet_pkg::ST_PRESSED) begin
                     btn_state[i] = kbet_pkg::ST_DOWN;
                  end else if (btn_state[i] == kbet_pkg::ST_RELEASED) begin
                     btn_state[i] = kbet_pkg::ST_UP;
                  end
               end
               btn_touched[i] = 1'b0;
               if (!r.held_button_found &&
                   (btn_state[i] == kbet_pkg::ST_PRESSED ||
                    btn_state[i] == kbet_pkg::ST_DOWN)) begin
                  r.held_button       = i[2:0];
                  r.held_button_found = 1'b1;
               end
            end
            r.scroll_x    = wheel_x;
            r.scroll_y    = wheel_y;
            r.scroll_seen = (wheel_x != 0) || (wheel_y != 0);
            r.move_dx     = delta_x;
            r.move_dy     = delta_y;
            wheel_x       = '0;
            wheel_y       = '0;
            delta_x       = '0;
            delta_y       = '0;
         end
         kbet_pkg::MODE_KEY_QUERY: begin
            if (code < kbet_pkg::KEY_COUNT) begin
               r.item_state = key_state[code];
            end
         end
         kbet_pkg::MODE_BTN_QUERY: begin
            if (code < kbet_pkg::BUTTON_COUNT) begin
               r.item_state = btn_state[code];
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic compare_field(input string name, input logic signed [16:0] want_v,
                                input logic signed [16:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      tracker_result_type got, want;
      int i;
      if (reset) begin
         for (i = 0; i < kbet_pkg::KEY_COUNT; i++) begin
            key_state[i]   = kbet_pkg::ST_UP;
            key_touched[i] = 1'b0;
         end
         for (i = 0; i < kbet_pkg::BUTTON_COUNT; i++) begin
            btn_state[i]   = kbet_pkg::ST_UP;
            btn_touched[i] = 1'b0;
         end
         wheel_x = '0;
         wheel_y = '0;
         last_x  = '0;
         last_y  = '0;
         delta_x = '0;
         delta_y = '0;
         owed_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(tracker_result_type)-1:0];
            if (owed_results.size() == 0) begin
               $error("response beat with no request waiting");
               mismatch_count++;
            end else begin
               want = owed_results.pop_front();
               compare_field("item_state", want.item_state, got.item_state);
               compare_field("held_key", want.held_key, got.held_key);
               compare_field("held_key_found", want.held_key_found, got.held_key_found);
               compare_field("held_button", want.held_button, got.held_button);
               compare_field("held_button_found", want.held_button_found,
                             got.held_button_found);
               compare_field("scroll_x", want.scroll_x, got.scroll_x);
               compare_field("scroll_y", want.scroll_y, got.scroll_y);
               compare_field("scroll_seen", want.scroll_seen, got.scroll_seen);
               compare_field("move_dx", want.move_dx, got.move_dx);
               compare_field("move_dy", want.move_dy, got.move_dy);
            end
         end
         if (req_tvalid && req_tready) begin
            owed_results = {owed_results,
                            tracker_response(req_tuser, req_tdata[8:0],
                                             req_tdata[24:9], req_tdata[40:25])};
         end
      end
      responses_owed = owed_results.size();
   end

endmodule

>>> dv/tb_key_button_edge_tracker_top.sv
// ============================================================================
// tb_key_button_edge_tracker_top: testbench for the key and button tracker
// Drives directed and random event, query, tick and unknown-mode beats into
// the tracker with random gaps on both streams and one long response stall,
// while a checker beside the block predicts and compares every response.
// ============================================================================
module tb_key_button_edge_tracker_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BEATS   = 1300;
   localparam int DRAIN_CYCLES   = kbet_pkg::KEY_COUNT + 64;
   localparam int HOLD_CYCLES    = 600;
   localparam int WATCHDOG_LIMIT = 8 * kbet_pkg::KEY_COUNT + 2000;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [kbet_pkg::REQ_W-1:0] req_tdata  = '0;
   logic [3:0]                 req_tuser  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [kbet_pkg::RSP_W-1:0] rsp_tdata;

   int mismatch_count;
   int responses_owed;
   int send_idle_pct = 7;
   int recv_idle_pct = 51;
   bit hold_go       = 1'b0;
   int quiet_cycles  = 0;

   key_button_edge_tracker_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   key_button_edge_tracker_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .responses_owed (responses_owed)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_key_button_edge_tracker_top: FAIL");
         $finish;
      end
   end

   // The receiver owns its stall counting; the main process only asks for the stall.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            for (int n = 0; n < HOLD_CYCLES; n++) begin
               rsp_tready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_beat(input logic [3:0] mode, input logic [8:0] code,
                            input logic [15:0] px, input logic [15:0] py);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {7'b0, py, px, code};
      do begin
         @(posedge clock);
      end while (!req_tready);
   endtask

   function automatic logic [8:0] pick_key();
      case ($urandom_range(9))
         0, 1:    return 9'($urandom_range(511));
         2:       return 9'(511 - $urandom_range(3));
         default: return 9'($urandom_range(11));
      endcase
   endfunction

   function automatic logic [8:0] pick_button();
      if ($urandom_range(9) == 0) begin
         return 9'($urandom_range(511));
      end
      return 9'($urandom_range(kbet_pkg::BUTTON_COUNT - 1));
   endfunction

   function automatic logic [15:0] pick_wheel_step();
      case ($urandom_range(3))
         0:       return ($urandom_range(1) != 0) ? 16'h7fff : 16'h8000;
         1:       return 16'($urandom_range(15)) - 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random_beat();
      int w;
      w = $urandom_range(99);
      if (w < 20) begin
         send_beat(kbet_pkg::MODE_KEY_DOWN, pick_key(), 16'($urandom), 16'($urandom));
      end else if (w < 35) begin
         send_beat(kbet_pkg::MODE_KEY_UP, pick_key(), 16'($urandom), 16'($urandom));
      end else if (w < 45) begin
         send_beat(kbet_pkg::MODE_WHEEL, 9'($urandom), pick_wheel_step(),
                   pick_wheel_step());
      end else if (w < 55) begin
         send_beat(kbet_pkg::MODE_MOTION, 9'($urandom), 16'($urandom), 16'($urandom));
      end else if (w < 63) begin
         send_beat(kbet_pkg::MODE_BTN_UP, pick_button(), 16'($urandom), 16'($urandom));
      end else if (w < 71) begin
         send_beat(kbet_pkg::MODE_BTN_DOWN, pick_button(), 16'($urandom),
                   16'($urandom));
      end else if (w < 76) begin
         send_beat(kbet_pkg::MODE_TICK, 9'($urandom), 16'($urandom), 16'($urandom));
      end else if (w < 87) begin
         send_beat(kbet_pkg::MODE_KEY_QUERY, pick_key(), 16'($urandom), 16'($urandom));
      end else if (w < 96) begin
         send_beat(kbet_pkg::MODE_BTN_QUERY, pick_button(), 16'($urandom),
                   16'($urandom));
      end else begin
         send_beat(4'(kbet_pkg::MODE_BTN_QUERY) + 4'($urandom_range(1, 7)),
                   9'($urandom), 16'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_beat(kbet_pkg::MODE_TICK, 9'd0, 16'h0000, 16'h0000);
      send_beat(kbet_pkg::MODE_KEY_QUERY, 9'd0, 16'h0000, 16'h0000);
      send_beat(kbet_pkg::MODE_KEY_DOWN, 9'd0, 16'hffff, 16'hffff);
      send_beat(kbet_pkg::MODE_KEY_DOWN, 9'd0, 16'h0000, 16'h0000);
      send_beat(kbet_pkg::MODE_KEY_DOWN, 9'd511, 16'h0000, 16'h0000);
      send_beat(kbet_pkg::MODE_KEY_UP, 9'd511, 16'h0000, 16'h0000);
      send_beat(kbet_pkg::MODE_KEY_QUERY, 9'd511, 16'h0000, 16'h0000);
      send_beat(kbet_pkg::MODE_BTN_DOWN, 9'd7, 16'h0000, 16'h0000);
      send_beat(kbet_pkg::MODE_BTN_DOWN, 9'd8, 16'h0000, 16'h0000);
      send_beat(kbet_pkg::MODE_BTN_UP, 9'd0, 16'h0000, 16'h0000);
      send_beat(kbet_pkg::MODE_BTN_QUERY, 9'd7, 16'h0000, 16'h0000);
      send_beat(kbet_pkg::MODE_BTN_QUERY, 9'd511, 16'h0000, 16'h0000);
      send_beat(kbet_pkg::MODE_WHEEL, 9'd0, 16'h7fff, 16'h8000);
      send_beat(kbet_pkg::MODE_WHEEL, 9'd0, 16'h0001, 16'hffff);
      send_beat(kbet_pkg::MODE_MOTION, 9'd0, 16'h8000, 16'h7fff);
      send_beat(kbet_pkg::MODE_MOTION, 9'd0, 16'h7fff, 16'h8000);
      send_beat(kbet_pkg::MODE_TICK, 9'd0, 16'h0000, 16'h0000);
      send_beat(kbet_pkg::MODE_TICK, 9'd0, 16'h0000, 16'h0000);
      send_beat(kbet_pkg::MODE_KEY_QUERY, 9'd0, 16'h0000, 16'h0000);
      send_beat(kbet_pkg::MODE_KEY_DOWN, 9'd0, 16'h0000, 16'h0000);
      send_beat(kbet_pkg::MODE_KEY_UP, 9'd0, 16'h0000, 16'h0000);
      send_beat(kbet_pkg::MODE_TICK, 9'd0, 16'h0000, 16'h0000);
      send_beat(kbet_pkg::MODE_TICK, 9'd0, 16'h0000, 16'h0000);
      send_beat(4'(kbet_pkg::MODE_BTN_QUERY) + 4'd1, 9'h1ff, 16'hffff, 16'hffff);
      send_beat(4'hf, 9'h1ff, 16'hffff, 16'hffff);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n == RANDOM_BEATS / 3) begin
            send_idle_pct = 51;
            recv_idle_pct = 7;
         end else if (n == 2 * RANDOM_BEATS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_go       = 1'b1;
         end
         send_random_beat();
      end
      req_tvalid <= 1'b0;

      while (responses_owed != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_key_button_edge_tracker_top: PASS");
      end else begin
         $display("tb_key_button_edge_tracker_top: FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/kbet_pkg.sv
rtl/core/kbet_key_ram.sv
rtl/core/kbet_button_file.sv
rtl/core/kbet_motion_unit.sv
rtl/core/key_button_edge_tracker_top.sv
dv/key_button_edge_tracker_checker.sv
dv/tb_key_button_edge_tracker_top.sv
